FILE: rtl/core/mbrvd_pkg.sv
// Shared types and codes for the meter-bus record value decoder.
`timescale 1ns / 1ps
`default_nettype none

package mbrvd_pkg;

    // Result kinds carried on the master-side tuser
    localparam logic [2:0] K_NONE     = 3'd0;
    localparam logic [2:0] K_INT      = 3'd1;
    localparam logic [2:0] K_BCD      = 3'd2;
    localparam logic [2:0] K_FLOAT    = 3'd3;
    localparam logic [2:0] K_DATE     = 3'd4;
    localparam logic [2:0] K_DATETIME = 3'd5;
    localparam logic [2:0] K_SOFT     = 3'd6;
    localparam logic [2:0] K_UNKNOWN  = 3'd7;

    localparam logic [11:0] YEAR_BASE    = 12'd2000;
    localparam logic [11:0] YEAR_INVALID = 12'd1900;
    localparam logic [3:0]  MONTH_INVALID = 4'd1;

    // Number of payload bytes that can carry BCD digits
    localparam int unsigned BcdBytes = 6;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] int_value;
        logic [31:0] float_bits;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        summer;
    } t_rec;

    // Per-byte BCD digit pair folded to binary (0..165)
    typedef logic [BcdBytes-1:0][7:0] t_bcd_pairs;

endpackage

`default_nettype wire

FILE: rtl/core/mbrvd_field_dec.sv
// Coding dispatch and field extraction for one meter-bus data record.
`timescale 1ns / 1ps
`default_nettype none

module mbrvd_field_dec (
    input  logic [7:0]             i_info,
    input  logic [7:0]             i_vif,
    input  logic [7:0]             i_vife,
    input  logic [63:0]            i_payload,
    output mbrvd_pkg::t_rec        o_rec,
    output mbrvd_pkg::t_bcd_pairs  o_bcd
);
    import mbrvd_pkg::*;

    localparam logic [3:0] COD_NONE    = 4'h0;
    localparam logic [3:0] COD_INT8    = 4'h1;
    localparam logic [3:0] COD_INT16   = 4'h2;
    localparam logic [3:0] COD_INT24   = 4'h3;
    localparam logic [3:0] COD_INT32   = 4'h4;
    localparam logic [3:0] COD_REAL    = 4'h5;
    localparam logic [3:0] COD_INT48   = 4'h6;
    localparam logic [3:0] COD_INT64   = 4'h7;
    localparam logic [3:0] COD_SEL     = 4'h8;
    localparam logic [3:0] COD_BCD2    = 4'h9;
    localparam logic [3:0] COD_BCD4    = 4'hA;
    localparam logic [3:0] COD_BCD6    = 4'hB;
    localparam logic [3:0] COD_BCD8    = 4'hC;
    localparam logic [3:0] COD_VAR     = 4'hD;
    localparam logic [3:0] COD_BCD12   = 4'hE;
    localparam logic [3:0] COD_SPECIAL = 4'hF;

    localparam logic [6:0] VIF_DATE     = 7'h6C;
    localparam logic [6:0] VIF_DATETIME = 7'h6D;
    localparam logic [7:0] VIF_EXT_FD   = 8'hFD;
    localparam logic [6:0] VIFE_STAMP_A = 7'h30;
    localparam logic [6:0] VIFE_STAMP_B = 7'h70;

    function automatic logic [11:0] year_of(input logic [7:0] lo, input logic [7:0] hi);
        return YEAR_BASE + {5'd0, hi[7:4], lo[7:5]};
    endfunction

    logic [3:0]          w_coding;
    logic [6:0]          w_vif7;
    logic [6:0]          w_vife7;
    logic                w_stamp;
    logic [7:0]          w_b0, w_b1, w_b2, w_b3, w_b4;
    logic [BcdBytes-1:0] w_keep;
    t_rec                w_rec;

    assign w_coding = i_info[3:0];
    assign w_vif7   = i_vif[6:0];
    assign w_vife7  = i_vife[6:0];
    assign w_stamp  = (w_vif7 == VIF_DATETIME) ||
                      ((i_vif == VIF_EXT_FD) &&
                       ((w_vife7 == VIFE_STAMP_A) || (w_vife7 == VIFE_STAMP_B)));
    assign w_b0 = i_payload[7:0];
    assign w_b1 = i_payload[15:8];
    assign w_b2 = i_payload[23:16];
    assign w_b3 = i_payload[31:24];
    assign w_b4 = i_payload[39:32];

    always_comb begin
        w_rec            = '0;
        w_rec.kind       = K_NONE;
        w_rec.year       = YEAR_INVALID;
        w_rec.month      = MONTH_INVALID;
        w_keep           = '0;
        unique case (w_coding)
            COD_NONE: begin
                w_rec.kind = K_NONE;
            end
            COD_INT8: begin
                w_rec.kind      = K_INT;
                w_rec.int_value = {{56{i_payload[7]}}, i_payload[7:0]};
            end
            COD_INT16: begin
                if (w_vif7 == VIF_DATE) begin
                    w_rec.kind  = K_DATE;
                    w_rec.day   = w_b0[4:0];
                    w_rec.month = w_b1[3:0];
                    w_rec.year  = year_of(w_b0, w_b1);
                end else begin
                    w_rec.kind      = K_INT;
                    w_rec.int_value = {{48{i_payload[15]}}, i_payload[15:0]};
                end
            end
            COD_INT24: begin
                w_rec.kind      = K_INT;
                w_rec.int_value = {{40{i_payload[23]}}, i_payload[23:0]};
            end
            COD_INT32: begin
                if (w_stamp) begin
                    w_rec.kind = K_DATETIME;
                    // Invalid-time flag sits in byte 0 bit 7
                    if (!w_b0[7]) begin
                        w_rec.minute = w_b0[5:0];
                        w_rec.hour   = w_b1[4:0];
                        w_rec.day    = w_b2[4:0];
                        w_rec.month  = w_b3[3:0];
                        w_rec.year   = year_of(w_b2, w_b3);
                        w_rec.summer = w_b1[7];
                    end
                end else begin
                    w_rec.kind      = K_INT;
                    w_rec.int_value = {{32{i_payload[31]}}, i_payload[31:0]};
                end
            end
            COD_REAL: begin
                w_rec.kind       = K_FLOAT;
                w_rec.float_bits = i_payload[31:0];
            end
            COD_INT48: begin
                if (w_stamp) begin
                    w_rec.kind = K_DATETIME;
                    // Invalid-time flag sits in byte 1 bit 7
                    if (!w_b1[7]) begin
                        w_rec.second = w_b0[5:0];
                        w_rec.minute = w_b1[5:0];
                        w_rec.hour   = w_b2[4:0];
                        w_rec.day    = w_b3[4:0];
                        w_rec.month  = w_b4[3:0];
                        w_rec.year   = year_of(w_b3, w_b4);
                        w_rec.summer = w_b0[6];
                    end
                end else begin
                    w_rec.kind      = K_INT;
                    w_rec.int_value = {{16{i_payload[47]}}, i_payload[47:0]};
                end
            end
            COD_INT64: begin
                w_rec.kind      = K_INT;
                w_rec.int_value = i_payload;
            end
            COD_SEL: begin
                w_rec.kind = K_UNKNOWN;
            end
            COD_BCD2: begin
                w_rec.kind = K_BCD;
                w_keep     = 6'b000001;
            end
            COD_BCD4: begin
                w_rec.kind = K_BCD;
                w_keep     = 6'b000011;
            end
            COD_BCD6: begin
                w_rec.kind = K_BCD;
                w_keep     = 6'b000111;
            end
            COD_BCD8: begin
                w_rec.kind = K_BCD;
                w_keep     = 6'b001111;
            end
            COD_BCD12: begin
                w_rec.kind = K_BCD;
                w_keep     = 6'b111111;
            end
            COD_VAR, COD_SPECIAL: begin
                w_rec.kind = K_SOFT;
            end
            default: begin
                w_rec.kind = K_UNKNOWN;
            end
        endcase
    end

    // Fold each byte's two digits into hi*10 + lo; drop bytes past the length
    always_comb begin
        logic [7:0] byte_v;
        for (int i = 0; i < BcdBytes; i++) begin
            byte_v   = w_keep[i] ? i_payload[8*i +: 8] : 8'd0;
            o_bcd[i] = {1'b0, byte_v[7:4], 3'b000} + {3'b000, byte_v[7:4], 1'b0}
                     + {4'b0000, byte_v[3:0]};
        end
    end

    assign o_rec = w_rec;

endmodule

`default_nettype wire

FILE: rtl/core/meter_bus_record_value_decoder.sv
// Top level: five-stage pipelined meter-bus data record value decoder.
// Each record passes the registers of stages A, B, C, D and E in turn to the master side.
// Throughput: one record per cycle while the sink does not stall; the depth follows the
// BCD multiply-add chain (digit pairs, then x100, then x10000 twice), one constant
// multiply per stage.
// Reset (synchronous, active low) clears the stage valid bits only; payload
// registers keep whatever they hold until the next record passes.
`timescale 1ns / 1ps
`default_nettype none

module meter_bus_record_value_decoder (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Record in
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [7:0] info_byte, [15:8] value_info_byte, [23:16] value_info_ext,
    // [87:24] payload_bytes
    input  logic [87:0]  s_axis_tdata,
    // Decoded value out
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [63:0] int_value, [95:64] float_bits, [107:96] year_out, [111:108] month_out,
    // [116:112] day_out, [121:117] hour_out, [127:122] minute_out,
    // [133:128] second_out, [134] summer_time, [135] zero
    output logic [135:0] m_axis_tdata,
    // [2:0] kind
    output logic [2:0]   m_axis_tuser
);
    import mbrvd_pkg::*;

    localparam logic [14:0] PAIR_WEIGHT = 15'd100;    // two digits per byte
    localparam logic [27:0] QUAD_WEIGHT = 28'd10000;  // four digits per byte pair
    localparam logic [41:0] QUAD_WIDE   = 42'd10000;

    // Handshake: each stage advances when empty or when the next one advances
    logic w_adv_a, w_adv_b, w_adv_c, w_adv_d, w_adv_e;

    // Stage A: registered record
    logic        r_a_vld;
    logic [87:0] r_a_data;

    // Stage B: decoded fields and per-byte digit pairs
    logic       r_b_vld;
    t_rec       r_b_rec;
    t_bcd_pairs r_b_bcd;
    t_rec       n_b_rec;
    t_bcd_pairs n_b_bcd;

    // Stage C: byte pairs, four digits each (max 16665)
    logic             r_c_vld;
    t_rec             r_c_rec;
    logic [2:0][14:0] r_c_pair;
    logic [2:0][14:0] n_c_pair;

    // Stage D: upper eight digits and lower four digits
    logic        r_d_vld;
    t_rec        r_d_rec;
    logic [27:0] r_d_hi;
    logic [14:0] r_d_lo;
    logic [27:0] n_d_hi;

    // Stage E: output register
    logic        r_e_vld;
    t_rec        r_e_rec;
    t_rec        n_e_rec;
    logic [41:0] w_bcd_full;

    assign w_adv_e = !r_e_vld || m_axis_tready;
    assign w_adv_d = !r_d_vld || w_adv_e;
    assign w_adv_c = !r_c_vld || w_adv_d;
    assign w_adv_b = !r_b_vld || w_adv_c;
    assign w_adv_a = !r_a_vld || w_adv_b;
    assign s_axis_tready = w_adv_a;

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
        end else begin
            if (w_adv_a) r_a_vld <= s_axis_tvalid;
            if (w_adv_b) r_b_vld <= r_a_vld;
            if (w_adv_c) r_c_vld <= r_b_vld;
            if (w_adv_d) r_d_vld <= r_c_vld;
            if (w_adv_e) r_e_vld <= r_d_vld;
        end
    end

    // Stage A: capture the transfer
    always_ff @(posedge i_clk) begin
        if (w_adv_a && s_axis_tvalid) begin
            r_a_data <= s_axis_tdata;
        end
    end

    // Stage B: dispatch on the coding nibble
    mbrvd_field_dec u_field_dec (
        .i_info    (r_a_data[7:0]),
        .i_vif     (r_a_data[15:8]),
        .i_vife    (r_a_data[23:16]),
        .i_payload (r_a_data[87:24]),
        .o_rec     (n_b_rec),
        .o_bcd     (n_b_bcd)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv_b && r_a_vld) begin
            r_b_rec <= n_b_rec;
            r_b_bcd <= n_b_bcd;
        end
    end

    // Stage C: combine adjacent bytes, high byte weighted by 100
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_c_pair[k] = {7'd0, r_b_bcd[2*k+1]} * PAIR_WEIGHT + {7'd0, r_b_bcd[2*k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_c && r_b_vld) begin
            r_c_rec  <= r_b_rec;
            r_c_pair <= n_c_pair;
        end
    end

    // Stage D: fold the top two pairs
    assign n_d_hi = {13'd0, r_c_pair[2]} * QUAD_WEIGHT + {13'd0, r_c_pair[1]};

    always_ff @(posedge i_clk) begin
        if (w_adv_d && r_c_vld) begin
            r_d_rec <= r_c_rec;
            r_d_hi  <= n_d_hi;
            r_d_lo  <= r_c_pair[0];
        end
    end

    // Stage E: finish the BCD value and pick it for BCD records
    assign w_bcd_full = {14'd0, r_d_hi} * QUAD_WIDE + {27'd0, r_d_lo};

    always_comb begin
        n_e_rec = r_d_rec;
        if (r_d_rec.kind == K_BCD) begin
            n_e_rec.int_value = {22'd0, w_bcd_full};
        end
    end

    // Hold the result while the sink stalls
    always_ff @(posedge i_clk) begin
        if (w_adv_e && r_d_vld) begin
            r_e_rec <= n_e_rec;
        end
    end

    assign m_axis_tvalid = r_e_vld;
    assign m_axis_tuser  = r_e_rec.kind;
    assign m_axis_tdata  = {1'b0, r_e_rec.summer, r_e_rec.second, r_e_rec.minute,
                            r_e_rec.hour, r_e_rec.day, r_e_rec.month, r_e_rec.year,
                            r_e_rec.float_bits, r_e_rec.int_value};

`ifndef SYNTHESIS
    // The input side only backs up when every stage holds a record
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_a_vld && r_b_vld && r_c_vld && r_d_vld && r_e_vld))
        else $error("input stalled with an empty pipeline stage");

    // An accepted transfer always lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_a_vld)
        else $error("accepted record not captured");

    // Twelve BCD digits never exceed 42 bits
    a_bcd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_e_vld && (r_e_rec.kind == K_BCD)) |-> (r_e_rec.int_value[63:42] == 22'd0))
        else $error("BCD result out of range");

    // Non-date results carry the invalid-date filler
    a_date_filler: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_e_vld && (r_e_rec.kind != K_DATE) && (r_e_rec.kind != K_DATETIME))
        |-> ((r_e_rec.year == YEAR_INVALID) && (r_e_rec.month == MONTH_INVALID)))
        else $error("date fields set on a non-date record");

    // Integer field stays clear for kinds that carry no integer
    a_int_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_e_vld && (r_e_rec.kind != K_INT) && (r_e_rec.kind != K_BCD))
        |-> (r_e_rec.int_value == 64'd0))
        else $error("integer field set on a non-integer record");
`endif

endmodule

`default_nettype wire
